// ===== hw/rtl/wmawm_pkg.sv =====
// Package for the WLAN management attack window monitor.
// Holds widths, frame decode codes, alert encoding and the result record.
// No dependencies.
package wmawm_pkg;

    // Width of the per-window frame counters and their snapshots
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEAUTH_THR = 3'd0,
        CFG_BEACON_THR = 3'd1,
        CFG_PROBE_THR  = 3'd2,
        CFG_WINDOW_MS  = 3'd3,
        CFG_COOLDOWN   = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_DEAUTH_THR = 16'd10;
    localparam logic [15:0] RST_BEACON_THR = 16'd100;
    localparam logic [15:0] RST_PROBE_THR  = 16'd50;
    localparam logic [15:0] RST_WINDOW_MS  = 16'd1000;
    localparam logic [31:0] RST_COOLDOWN   = 32'd30000;

    // Input item kind
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // 802.11 frame-control decode
    localparam logic [1:0] FTYPE_MGMT       = 2'h0;
    localparam logic [3:0] SUB_DEAUTH       = 4'hC;
    localparam logic [3:0] SUB_DISASSOC     = 4'hA;
    localparam logic [3:0] SUB_PROBE_REQ    = 4'h4;
    localparam logic [3:0] SUB_BEACON       = 4'h8;

    typedef enum logic [2:0] {
        ALERT_AMBIENT = 3'd0,
        ALERT_DEAUTH  = 3'd1,
        ALERT_BEACON  = 3'd2,
        ALERT_PROBE   = 3'd3,
        ALERT_MULTI   = 3'd4
    } alert_t;

    typedef struct packed {
        alert_t      alert_state;
        logic        window_closed;
        logic [15:0] deauth_in_window;
        logic [15:0] probe_in_window;
        logic [15:0] beacon_in_window;
        logic        alert_logged;
        logic [31:0] alert_time;
        alert_t      alert_kind;
    } result_t;

    // Clamp a counter snapshot to the 16-bit output field
    function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

endpackage

// ===== hw/rtl/wmawm_if.sv =====
// Channel interfaces of the WLAN management attack window monitor.
// Valid/ready handshake; a transfer happens when both are high.
// No dependencies.
interface wmawm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] frame_control;

    modport source (output valid, output func, output frame_control, input ready);
    modport sink   (input valid, input func, input frame_control, output ready);
endinterface

interface wmawm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  alert_state;
    logic        window_closed;
    logic [15:0] deauth_in_window;
    logic [15:0] probe_in_window;
    logic [15:0] beacon_in_window;
    logic        alert_logged;
    logic [31:0] alert_time;
    logic [2:0]  alert_kind;

    modport source (output valid, output alert_state, output window_closed,
                    output deauth_in_window, output probe_in_window,
                    output beacon_in_window, output alert_logged,
                    output alert_time, output alert_kind, input ready);
    modport sink   (input valid, input alert_state, input window_closed,
                    input deauth_in_window, input probe_in_window,
                    input beacon_in_window, input alert_logged,
                    input alert_time, input alert_kind, output ready);
endinterface

// ===== hw/rtl/wlan_mgmt_attack_window_monitor_top.sv =====
// Throughput: one item per cycle while the skid register is free. Each result is
// registered in the result register, or in the skid register while a result stalls;
// this two-entry output buffer keeps input ready registered and lets that item in.
// Reset (rst_n low, asynchronous): all counters, time and snapshots clear, the
// alert returns to ambient, thresholds and window/cooldown take their defaults.
// Depends on wmawm_pkg and wmawm_if.
module wlan_mgmt_attack_window_monitor_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [wmawm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wmawm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    wmawm_in_if.sink                         item,
    wmawm_out_if.source                      result
);
    import wmawm_pkg::*;

    // Configuration registers
    logic [15:0] deauth_thr_reg;
    logic [15:0] beacon_thr_reg;
    logic [15:0] probe_thr_reg;
    logic [15:0] window_ms_reg;
    logic [31:0] cooldown_reg;

    // Detection state
    logic [31:0]           time_now_reg,     time_now_next;
    logic [15:0]           win_elapsed_reg,  win_elapsed_next;
    logic [COUNT_BITS-1:0] deauth_cnt_reg,   deauth_cnt_next;
    logic [COUNT_BITS-1:0] probe_cnt_reg,    probe_cnt_next;
    logic [COUNT_BITS-1:0] beacon_cnt_reg,   beacon_cnt_next;
    logic [31:0]           since_det_reg,    since_det_next;
    alert_t                cur_alert_reg,    cur_alert_next;
    logic [COUNT_BITS-1:0] last_deauth_reg,  last_deauth_next;
    logic [COUNT_BITS-1:0] last_probe_reg,   last_probe_next;
    logic [COUNT_BITS-1:0] last_beacon_reg,  last_beacon_next;

    // Output buffer: main result register and skid register
    result_t main_res_reg, skid_res_reg;
    logic    main_vld_reg, skid_vld_reg;

    result_t res_next;
    logic    accept;
    logic    pop;
    logic    win_close;
    logic    hit_deauth, hit_probe, hit_beacon;
    logic [1:0] hit_count;
    alert_t  new_alert;
    logic [15:0] elapsed_inc;
    logic [31:0] since_inc;
    logic [1:0]  ftype;
    logic [3:0]  subtype;

    // Input stays open as long as the skid register is free
    assign item.ready = !skid_vld_reg;
    assign accept     = item.valid && item.ready;
    assign pop        = main_vld_reg && result.ready;

    assign ftype   = item.frame_control[3:2];
    assign subtype = item.frame_control[7:4];

    assign elapsed_inc = (win_elapsed_reg == 16'hFFFF) ? win_elapsed_reg
                                                       : win_elapsed_reg + 16'd1;
    assign since_inc   = (since_det_reg == 32'hFFFF_FFFF) ? since_det_reg
                                                          : since_det_reg + 32'd1;
    assign win_close   = (item.func == FUNC_TICK) && (elapsed_inc >= window_ms_reg);

    // Threshold compares run on the live counters, which become the snapshots
    assign hit_deauth = 32'(deauth_cnt_reg) >= 32'(deauth_thr_reg);
    assign hit_probe  = 32'(probe_cnt_reg)  >= 32'(probe_thr_reg);
    assign hit_beacon = 32'(beacon_cnt_reg) >= 32'(beacon_thr_reg);
    assign hit_count  = 2'(hit_deauth) + 2'(hit_probe) + 2'(hit_beacon);

    always_comb
    begin
        priority if (hit_count >= 2'd2)
            new_alert = ALERT_MULTI;
        else if (hit_deauth)
            new_alert = ALERT_DEAUTH;
        else if (hit_beacon)
            new_alert = ALERT_BEACON;
        else
            new_alert = ALERT_PROBE;
    end

    // Next state and result for the item at the input
    always_comb
    begin
        time_now_next    = time_now_reg;
        win_elapsed_next = win_elapsed_reg;
        deauth_cnt_next  = deauth_cnt_reg;
        probe_cnt_next   = probe_cnt_reg;
        beacon_cnt_next  = beacon_cnt_reg;
        since_det_next   = since_det_reg;
        cur_alert_next   = cur_alert_reg;
        last_deauth_next = last_deauth_reg;
        last_probe_next  = last_probe_reg;
        last_beacon_next = last_beacon_reg;
        res_next.window_closed = 1'b0;
        res_next.alert_logged  = 1'b0;
        res_next.alert_time    = 32'd0;
        res_next.alert_kind    = ALERT_AMBIENT;

        if (item.func == FUNC_FRAME)
        begin
            // Count management frames of interest, saturating
            if (ftype == FTYPE_MGMT)
            begin
                priority if (subtype == SUB_DEAUTH || subtype == SUB_DISASSOC)
                    deauth_cnt_next = (deauth_cnt_reg == CNT_MAX) ? deauth_cnt_reg
                                                      : deauth_cnt_reg + COUNT_BITS'(1);
                else if (subtype == SUB_PROBE_REQ)
                    probe_cnt_next = (probe_cnt_reg == CNT_MAX) ? probe_cnt_reg
                                                    : probe_cnt_reg + COUNT_BITS'(1);
                else if (subtype == SUB_BEACON)
                    beacon_cnt_next = (beacon_cnt_reg == CNT_MAX) ? beacon_cnt_reg
                                                      : beacon_cnt_reg + COUNT_BITS'(1);
                else
                    deauth_cnt_next = deauth_cnt_reg;
            end
        end
        else
        begin
            // Advance time; close the window when it has run its length
            time_now_next    = time_now_reg + 32'd1;
            win_elapsed_next = elapsed_inc;
            since_det_next   = since_inc;
            if (win_close)
            begin
                res_next.window_closed = 1'b1;
                win_elapsed_next = 16'd0;
                last_deauth_next = deauth_cnt_reg;
                last_probe_next  = probe_cnt_reg;
                last_beacon_next = beacon_cnt_reg;
                deauth_cnt_next  = '0;
                probe_cnt_next   = '0;
                beacon_cnt_next  = '0;
                if (hit_count != 2'd0)
                begin
                    since_det_next = 32'd0;
                    cur_alert_next = new_alert;
                    if (new_alert != cur_alert_reg)
                    begin
                        res_next.alert_logged = 1'b1;
                        res_next.alert_time   = time_now_next;
                        res_next.alert_kind   = new_alert;
                    end
                end
                else if (cur_alert_reg != ALERT_AMBIENT && since_inc >= cooldown_reg)
                begin
                    cur_alert_next = ALERT_AMBIENT;
                end
            end
        end

        res_next.alert_state      = cur_alert_next;
        res_next.deauth_in_window = clamp16(last_deauth_next);
        res_next.probe_in_window  = clamp16(last_probe_next);
        res_next.beacon_in_window = clamp16(last_beacon_next);
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deauth_thr_reg <= RST_DEAUTH_THR;
            beacon_thr_reg <= RST_BEACON_THR;
            probe_thr_reg  <= RST_PROBE_THR;
            window_ms_reg  <= RST_WINDOW_MS;
            cooldown_reg   <= RST_COOLDOWN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEAUTH_THR: deauth_thr_reg <= cfg_data[15:0];
                CFG_BEACON_THR: beacon_thr_reg <= cfg_data[15:0];
                CFG_PROBE_THR:  probe_thr_reg  <= cfg_data[15:0];
                CFG_WINDOW_MS:  window_ms_reg  <= cfg_data[15:0];
                CFG_COOLDOWN:   cooldown_reg   <= cfg_data[31:0];
                default:        deauth_thr_reg <= deauth_thr_reg;
            endcase
        end
    end

    // Detection state: update on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg    <= 32'd0;
            win_elapsed_reg <= 16'd0;
            deauth_cnt_reg  <= '0;
            probe_cnt_reg   <= '0;
            beacon_cnt_reg  <= '0;
            since_det_reg   <= 32'd0;
            cur_alert_reg   <= ALERT_AMBIENT;
            last_deauth_reg <= '0;
            last_probe_reg  <= '0;
            last_beacon_reg <= '0;
        end
        else if (accept)
        begin
            time_now_reg    <= time_now_next;
            win_elapsed_reg <= win_elapsed_next;
            deauth_cnt_reg  <= deauth_cnt_next;
            probe_cnt_reg   <= probe_cnt_next;
            beacon_cnt_reg  <= beacon_cnt_next;
            since_det_reg   <= since_det_next;
            cur_alert_reg   <= cur_alert_next;
            last_deauth_reg <= last_deauth_next;
            last_probe_reg  <= last_probe_next;
            last_beacon_reg <= last_beacon_next;
        end
    end

    // Output buffer valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            // Skid full: input is held off; drain skid into main on transfer
            if (pop)
                skid_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (main_vld_reg && !pop)
                skid_vld_reg <= 1'b1;
            main_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_vld_reg <= 1'b0;
        end
    end

    // Output buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                main_res_reg <= skid_res_reg;
        end
        else if (accept)
        begin
            if (main_vld_reg && !pop)
                skid_res_reg <= res_next;
            else
                main_res_reg <= res_next;
        end
    end

    assign result.valid            = main_vld_reg;
    assign result.alert_state      = main_res_reg.alert_state;
    assign result.window_closed    = main_res_reg.window_closed;
    assign result.deauth_in_window = main_res_reg.deauth_in_window;
    assign result.probe_in_window  = main_res_reg.probe_in_window;
    assign result.beacon_in_window = main_res_reg.beacon_in_window;
    assign result.alert_logged     = main_res_reg.alert_logged;
    assign result.alert_time       = main_res_reg.alert_time;
    assign result.alert_kind       = main_res_reg.alert_kind;

    // Skid register only fills behind a full main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> main_vld_reg)
        else $error("skid register valid while result register empty");

    // A logged alert comes only from a window close and matches the new state
    a_log_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (main_vld_reg && main_res_reg.alert_logged) |->
        (main_res_reg.window_closed && main_res_reg.alert_kind == main_res_reg.alert_state
         && main_res_reg.alert_kind != ALERT_AMBIENT))
        else $error("logged alert without matching window close");

    // Closing a window clears all frame counters
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && win_close) |=>
        (deauth_cnt_reg == '0 && probe_cnt_reg == '0 && beacon_cnt_reg == '0
         && win_elapsed_reg == 16'd0))
        else $error("counters not cleared at window close");

    // Alert state changes only on a window close
    a_alert_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && win_close) |=> $stable(cur_alert_reg))
        else $error("alert state changed outside a window close");

endmodule
